### design/mrcs_pkg.sv
// Shared constants and helpers for the matrix row/column sorter.
// No dependencies; imported by mrcs_ram users and the top level.
`default_nettype none

package mrcs_pkg;

    // Matrix geometry
    localparam int ROWS_MAX  = 8;
    localparam int COLS_MAX  = 8;
    localparam int DEPTH     = ROWS_MAX * COLS_MAX;
    localparam int ADDR_W    = $clog2(DEPTH);

    // Field widths
    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int ROW_W     = 3;
    localparam int COL_W     = 3;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SORT_BY_ROW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DESCENDING  = 2'd3;

    typedef logic [DIM_W-1:0]  dim_t;
    typedef logic [ADDR_W-1:0] addr_t;

    // Limit a configured dimension to 1..max
    function automatic dim_t clamp_dim(input dim_t v, input dim_t max_v);
        dim_t res;
        if (v == '0)
            res = dim_t'(1);
        else if (v > max_v)
            res = max_v;
        else
            res = v;
        return res;
    endfunction

    // Store location of element (r, c)
    function automatic addr_t addr_of(input logic [ROW_W-1:0] r,
                                      input logic [COL_W-1:0] c);
        addr_t res;
        res = ADDR_W'(int'(r) * COLS_MAX + int'(c));
        return res;
    endfunction

endpackage

`default_nettype wire

### design/mrcs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module mrcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### design/matrix_row_column_sort.sv
// Top level of the matrix row/column sorter: load, bubble sort and emission
// sequencer around one 64 x 32 RAM. Depends on mrcs_pkg and mrcs_ram.
`default_nettype none

// Elements are taken one per cycle (start high, busy low) in row-major order.
// The element that completes a row_count x col_count matrix raises busy; the
// block then sorts each row (or column) with bubble passes and emits the whole
// matrix in row-major order, one result per cycle on result_valid, which the
// receiver must take as it comes. Every compare-and-swap reads the RAM once
// and writes it once, the element that bubbles forward being carried in a
// register, so one compare fits in each cycle. With n elements per line and
// L lines the sort runs the L lines in turn (it is skipped when n is 1),
// then all rows*cols results are emitted. Configuration writes are always
// taken at once and must only be issued while busy is low and the last
// result has gone out.
module matrix_row_column_sort (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // element request
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic signed [mrcs_pkg::DATA_W-1:0] element,
    // configuration writes
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [mrcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [mrcs_pkg::DIM_W-1:0]      cfg_data,
    // results
    output logic                                 result_valid,
    output logic signed [mrcs_pkg::DATA_W-1:0]   sorted_value,
    output logic [mrcs_pkg::ROW_W-1:0]           row_index,
    output logic [mrcs_pkg::COL_W-1:0]           col_index,
    output logic                                 last_of_run
);

    import mrcs_pkg::*;

    localparam logic [1:0] ST_LOAD  = 2'd0;
    localparam logic [1:0] ST_SORT  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    // Configuration
    dim_t row_count_reg, col_count_reg;
    logic sort_by_row_reg, descending_reg;

    logic [1:0] state_reg, state_next;

    // Load position
    logic [ROW_W-1:0] ld_r_reg;
    logic [COL_W-1:0] ld_c_reg;

    // Sort sequencer
    logic [ROW_W-1:0] ln_reg;      // current line
    logic [ROW_W-1:0] pass_reg;
    logic [ROW_W-1:0] j_reg;       // element within line being read

    // Compare stage
    logic                     s1_valid_reg, s1_first_reg, s1_last_reg;
    addr_t                    s1_addr_reg, prev_addr_reg, flush_addr_reg;
    logic                     flush_reg;
    logic signed [DATA_W-1:0] carry_reg, carry_next;

    // Emission
    logic [ROW_W-1:0] e_r_reg, o_row_reg;
    logic [COL_W-1:0] e_c_reg, o_col_reg;
    logic             o_valid_reg, o_last_reg;

    // RAM ports
    logic                 ram_we;
    addr_t                ram_waddr, ram_raddr;
    logic [DATA_W-1:0]    ram_wdata, ram_rdata;

    dim_t rows, cols, line_len, line_cnt, lim;
    logic in_accept, load_done, skip_sort;
    logic issue, j_end, pass_end, line_end;
    logic emit_end;
    logic signed [DATA_W-1:0] rd_val;
    logic ooo, stay_we;
    addr_t sort_raddr;

    // Dimensions in use
    always_comb
    begin
        rows     = clamp_dim(row_count_reg, DIM_W'(ROWS_MAX));
        cols     = clamp_dim(col_count_reg, DIM_W'(COLS_MAX));
        line_len = sort_by_row_reg ? cols : rows;
        line_cnt = sort_by_row_reg ? rows : cols;
        lim      = line_len - dim_t'(1) - dim_t'(pass_reg);
    end

    assign busy      = (state_reg != ST_LOAD);
    assign cfg_ready = 1'b1;
    assign in_accept = start && !busy;
    assign load_done = (dim_t'(ld_c_reg) == cols - dim_t'(1))
                    && (dim_t'(ld_r_reg) == rows - dim_t'(1));
    assign skip_sort = (line_len < dim_t'(2));

    // Sort read sequencing
    assign issue      = (state_reg == ST_SORT);
    assign j_end      = (dim_t'(j_reg) == lim);
    assign pass_end   = (dim_t'(pass_reg) == line_len - dim_t'(2));
    assign line_end   = (dim_t'(ln_reg) == line_cnt - dim_t'(1));
    assign sort_raddr = sort_by_row_reg ? addr_of(ln_reg, j_reg) : addr_of(j_reg, ln_reg);

    assign emit_end = (dim_t'(e_r_reg) == rows - dim_t'(1))
                   && (dim_t'(e_c_reg) == cols - dim_t'(1));

    // Compare and carry: the element that must go later travels forward
    always_comb
    begin
        rd_val  = $signed(ram_rdata);
        ooo     = descending_reg ? (carry_reg < rd_val) : (carry_reg > rd_val);
        stay_we = s1_valid_reg && !s1_first_reg;
        if (s1_valid_reg && !s1_first_reg && ooo)
            carry_next = carry_reg;
        else if (s1_valid_reg)
            carry_next = rd_val;
        else
            carry_next = carry_reg;
    end

    // RAM write and read selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = prev_addr_reg;
        ram_wdata = carry_reg;
        priority if (in_accept)
        begin
            ram_we    = 1'b1;
            ram_waddr = addr_of(ld_r_reg, ld_c_reg);
            ram_wdata = element;
        end
        else if (stay_we)
        begin
            ram_we    = 1'b1;
            ram_waddr = prev_addr_reg;
            ram_wdata = ooo ? rd_val : carry_reg;
        end
        else if (flush_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = flush_addr_reg;
            ram_wdata = carry_reg;
        end
        ram_raddr = (state_reg == ST_EMIT) ? addr_of(e_r_reg, e_c_reg) : sort_raddr;
    end

    mrcs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // State sequencing
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_accept && load_done)
                    state_next = skip_sort ? ST_EMIT : ST_SORT;
            end
            ST_SORT:
            begin
                if (j_end && pass_end && line_end)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!s1_valid_reg && !flush_reg)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_end)
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg   <= dim_t'(8);
            col_count_reg   <= dim_t'(8);
            sort_by_row_reg <= 1'b1;
            descending_reg  <= 1'b0;
            state_reg       <= ST_LOAD;
            ld_r_reg        <= '0;
            ld_c_reg        <= '0;
            ln_reg          <= '0;
            pass_reg        <= '0;
            j_reg           <= '0;
            s1_valid_reg    <= 1'b0;
            flush_reg       <= 1'b0;
            e_r_reg         <= '0;
            e_c_reg         <= '0;
            o_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Load position; a new dimension drops a partial matrix
            if (cfg_valid && cfg_ready &&
                (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT))
            begin
                ld_r_reg <= '0;
                ld_c_reg <= '0;
            end
            else if (in_accept)
            begin
                if (dim_t'(ld_c_reg) == cols - dim_t'(1))
                begin
                    ld_c_reg <= '0;
                    ld_r_reg <= load_done ? '0 : ld_r_reg + 1'b1;
                end
                else
                begin
                    ld_c_reg <= ld_c_reg + 1'b1;
                end
            end

            // Configuration register writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT:   row_count_reg   <= cfg_data;
                    REG_COL_COUNT:   col_count_reg   <= cfg_data;
                    REG_SORT_BY_ROW: sort_by_row_reg <= cfg_data[0];
                    REG_DESCENDING:  descending_reg  <= cfg_data[0];
                    default:         ;
                endcase
            end

            // Sort read counters: j over a pass, passes over a line, lines
            if (issue)
            begin
                if (j_end)
                begin
                    j_reg <= '0;
                    if (pass_end)
                    begin
                        pass_reg <= '0;
                        ln_reg   <= line_end ? '0 : ln_reg + 1'b1;
                    end
                    else
                    begin
                        pass_reg <= pass_reg + 1'b1;
                    end
                end
                else
                begin
                    j_reg <= j_reg + 1'b1;
                end
            end

            s1_valid_reg <= issue;
            flush_reg    <= s1_valid_reg && s1_last_reg;

            // Emission counters
            if (state_reg == ST_EMIT)
            begin
                if (dim_t'(e_c_reg) == cols - dim_t'(1))
                begin
                    e_c_reg <= '0;
                    e_r_reg <= emit_end ? '0 : e_r_reg + 1'b1;
                end
                else
                begin
                    e_c_reg <= e_c_reg + 1'b1;
                end
            end
            o_valid_reg <= (state_reg == ST_EMIT);
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_first_reg <= (j_reg == '0);
            s1_last_reg  <= j_end;
            s1_addr_reg  <= sort_raddr;
        end
        if (s1_valid_reg)
        begin
            prev_addr_reg  <= s1_addr_reg;
            flush_addr_reg <= s1_addr_reg;
        end
        carry_reg <= carry_next;
        o_row_reg  <= e_r_reg;
        o_col_reg  <= e_c_reg;
        o_last_reg <= emit_end;
    end

    assign result_valid = o_valid_reg;
    assign sorted_value = $signed(ram_rdata);
    assign row_index    = o_row_reg;
    assign col_index    = o_col_reg;
    assign last_of_run  = o_valid_reg && o_last_reg;

    // Checks
    a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
        !(stay_we && flush_reg))
        else $error("compare write and carry flush collide");

    a_flush_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> $past(s1_valid_reg && s1_last_reg))
        else $error("carry flush without a final compare");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == ST_EMIT))
        else $error("result outside emission");

    a_no_load_while_sorting: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg || flush_reg) |-> !in_accept)
        else $error("element accepted during sort");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        last_of_run |-> (state_reg == ST_LOAD))
        else $error("final result while still emitting");

endmodule

`default_nettype wire
